// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the rise point finder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is low.
`define RRPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define RRPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/rrpf_pkg.sv =====
// Package for the ramp rise point finder: widths, defaults, status codes
// and the result record. Depends on nothing.
package rrpf_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int POINT_W         = 12;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int LOW_LIMIT_DEF   = 409;
    localparam int SAT_LEVEL       = 4094;
    localparam int UPPER_LIMIT_RST = 2784;
    // First sample index at which the three-sample window can qualify point A
    localparam int FIRST_CHECK_IDX = 4;
    // Point B this close or closer to point A counts as overflow
    localparam int MIN_SPACING     = 2;

    // Stream widths; tdata widths padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // Register number taken from the address above the word offset
    localparam logic REG_UPPER_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [POINT_W-1:0]   point_a;
        logic [POINT_W-1:0]   point_b;
        logic [POINT_W-1:0]   spacing;
    } t_result;

endpackage

// ===== rtl/rrpf_search.sv =====
// Capture search for the ramp rise point finder: sample window, point A and
// point B tracking, and the status of a finished capture. Uses rrpf_pkg.
module rrpf_search #(
    parameter int MAX_SAMPLES = rrpf_pkg::MAX_SAMPLES_DEF,
    parameter int LOW_LIMIT   = rrpf_pkg::LOW_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rrpf_pkg::SAMPLE_W-1:0]  i_upper_limit,
    input  logic                           i_valid,
    input  logic [rrpf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_last,
    output logic                           o_push,
    output rrpf_pkg::t_result              o_result
);
    import rrpf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);

    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SAMPLE_W-1:0] r_win0, n_win0;
    logic [SAMPLE_W-1:0] r_win1, n_win1;
    logic                r_found_a, n_found_a;
    logic [IDX_W-1:0]    r_a_idx, n_a_idx;
    logic                r_a_sat, n_a_sat;
    logic                r_found_b, n_found_b;
    logic [IDX_W-1:0]    r_b_idx, n_b_idx;
    logic                r_b_sat, n_b_sat;

    logic                active;
    logic                s_above;
    logic                w1_above;
    logic                a_qual;
    logic [IDX_W-1:0]    span;

    // Qualify point A from the window and the new sample, catch point B
    always_comb begin
        active   = r_idx < IDX_W'(MAX_SAMPLES);
        s_above  = i_sample > i_upper_limit;
        w1_above = r_win1 > i_upper_limit;
        a_qual   = !r_found_a && (r_idx >= IDX_W'(FIRST_CHECK_IDX))
                   && (r_win0 > SAMPLE_W'(LOW_LIMIT))
                   && (r_win0 <= r_win1) && (r_win1 <= i_sample);

        n_idx     = r_idx;
        n_win0    = r_win0;
        n_win1    = r_win1;
        n_found_a = r_found_a;
        n_a_idx   = r_a_idx;
        n_a_sat   = r_a_sat;
        n_found_b = r_found_b;
        n_b_idx   = r_b_idx;
        n_b_sat   = r_b_sat;

        if (active) begin
            if (r_found_a && !r_found_b && s_above) begin
                n_found_b = 1'b1;
                n_b_idx   = r_idx;
                n_b_sat   = i_sample >= SAMPLE_W'(SAT_LEVEL);
            end
            if (a_qual) begin
                n_found_a = 1'b1;
                n_a_idx   = r_idx - IDX_W'(2);
                n_a_sat   = r_win0 >= SAMPLE_W'(SAT_LEVEL);
                // B may already sit one or two samples after A
                if (w1_above) begin
                    n_found_b = 1'b1;
                    n_b_idx   = r_idx - IDX_W'(1);
                    n_b_sat   = r_win1 >= SAMPLE_W'(SAT_LEVEL);
                end else if (s_above) begin
                    n_found_b = 1'b1;
                    n_b_idx   = r_idx;
                    n_b_sat   = i_sample >= SAMPLE_W'(SAT_LEVEL);
                end
            end
            n_win0 = r_win1;
            n_win1 = i_sample;
            n_idx  = r_idx + IDX_W'(1);
        end
    end

    // Form the capture result from the updated search state
    always_comb begin
        span             = n_b_idx - n_a_idx;
        o_push           = i_valid && i_last;
        o_result.status  = ST_OK;
        o_result.point_a = '0;
        o_result.point_b = '0;
        o_result.spacing = '0;
        if (!n_found_a || !n_found_b) begin
            o_result.status = ST_UNDERFLOW;
        end else if (span <= IDX_W'(MIN_SPACING) || n_a_sat || n_b_sat) begin
            o_result.status = ST_OVERFLOW;
        end else begin
            o_result.point_a = POINT_W'(n_a_idx);
            o_result.point_b = POINT_W'(n_b_idx);
            o_result.spacing = POINT_W'(span);
        end
    end

    // Advance the search on each sample, clear it after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
        end else if (i_valid) begin
            if (i_last) begin
                r_idx     <= '0;
                r_found_a <= 1'b0;
                r_found_b <= 1'b0;
            end else begin
                r_idx     <= n_idx;
                r_found_a <= n_found_a;
                r_found_b <= n_found_b;
            end
        end
    end

    // Hold window and point payload
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_win0  <= n_win0;
            r_win1  <= n_win1;
            r_a_idx <= n_a_idx;
            r_a_sat <= n_a_sat;
            r_b_idx <= n_b_idx;
            r_b_sat <= n_b_sat;
        end
    end

endmodule

// ===== rtl/rrpf_out.sv =====
// Result register with skid stage for the ramp rise point finder.
// Uses rrpf_pkg for the result record and stream widths.
module rrpf_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  rrpf_pkg::t_result               i_result,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_take_ready,
    output logic [rrpf_pkg::M_TDATA_W-1:0]  o_tdata,
    output logic [rrpf_pkg::M_TUSER_W-1:0]  o_tuser
);
    import rrpf_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take    = r_main_valid && i_take_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_tdata = {(M_TDATA_W - 3 * POINT_W)'(0),
                      r_main.spacing, r_main.point_b, r_main.point_a};
    assign o_tuser = r_main.status;

    // Track occupancy of the main and skid slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (take) begin
            r_main_valid <= 1'b0;
        end
    end

    // Move payload into the free slot, drain skid on a transaction
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !take) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule

// ===== rtl/ramp_rise_point_finder.sv =====
// Ramp rise point finder: stream sample search with an APB threshold register.
// Depends on rrpf_pkg, rrpf_search and rrpf_out.
//
// Use: feed ADC samples of one charging ramp on the s_axis channel,
// tdata[11:0] = sample, tlast on the final sample of the capture. Point A is
// the first index from 2 on above the low limit followed by two
// non-decreasing samples; point B the first later index above upper_limit.
// One result per capture leaves on m_axis: tuser = status (ok, underflow,
// overflow), tdata = point A, point B and their spacing.
// Throughput: one sample per cycle while s_axis_tready is high; the search is a
// single compare pass on a two-sample window between state and result registers.
// Output: the result register, or the skid slot while that register is still full,
// loads at the edge taking the last sample; m_axis_tvalid is high right after it.
// Stall: the output has a result register and a skid slot; s_axis_tready
// drops only while both hold results, and no result is lost or repeated.
// Reset (synchronous, active low) sets upper_limit to 2784, clears the
// capture search and empties the output slots.
// Write upper_limit at byte address 0 over APB only while idle.
module ramp_rise_point_finder #(
    parameter int MAX_SAMPLES = rrpf_pkg::MAX_SAMPLES_DEF,
    parameter int LOW_LIMIT   = rrpf_pkg::LOW_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rrpf_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [11:0] sample, rest zero
    input  logic                             s_axis_tlast,
    // result stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [11:0] point_a, [23:12] point_b, [35:24] spacing, [39:36] zero
    output logic [rrpf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [rrpf_pkg::M_TUSER_W-1:0]   m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rrpf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rrpf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import rrpf_pkg::*;

    logic [SAMPLE_W-1:0] r_upper_limit;
    logic                accept;
    logic                push;
    t_result             result;

    assign pready = 1'b1;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Write the threshold register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= SAMPLE_W'(UPPER_LIMIT_RST);
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_ADDR_W-1] == REG_UPPER_LIMIT) begin
            r_upper_limit <= pwdata[SAMPLE_W-1:0];
        end
    end

    // Read back the threshold register
    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_UPPER_LIMIT) begin
            prdata = APB_DATA_W'(r_upper_limit);
        end
    end

    rrpf_search #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .LOW_LIMIT   (LOW_LIMIT)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upper_limit (r_upper_limit),
        .i_valid       (accept),
        .i_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_result      (result)
    );

    rrpf_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_result     (result),
        .o_ready      (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .i_take_ready (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser)
    );

endmodule

// ===== rtl/rrpf_checker.sv =====
// Port-level checker for the ramp rise point finder, bound to the top level.
// Depends on rrpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrpf_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [rrpf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic [rrpf_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import rrpf_pkg::*;

    logic [POINT_W-1:0] pa;
    logic [POINT_W-1:0] pb;
    logic [POINT_W-1:0] sp;
    logic               is_ok;

    assign pa    = m_axis_tdata[POINT_W-1:0];
    assign pb    = m_axis_tdata[2*POINT_W-1:POINT_W];
    assign sp    = m_axis_tdata[3*POINT_W-1:2*POINT_W];
    assign is_ok = m_axis_tuser == ST_OK;

    // A failed capture reports no points
    `RRPF_ASSERT(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !is_ok |-> m_axis_tdata == '0, "points on failed capture")

    // A good capture has spacing equal to B minus A and wider than the guard
    `RRPF_ASSERT(a_ok_span, i_clk, i_rst_n, m_axis_tvalid && is_ok |-> POINT_W'(pb - pa) == sp && sp > POINT_W'(MIN_SPACING), "bad spacing on ok result")

    // Status is one of the three codes
    `RRPF_ASSERT_NEVER(a_status_code, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK && m_axis_tuser != ST_UNDERFLOW && m_axis_tuser != ST_OVERFLOW, "unknown status code")

    // A stalled result stays offered
    `RRPF_ASSERT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

endmodule

bind ramp_rise_point_finder rrpf_checker u_rrpf_checker (.*);

// ===== tb/tb_ramp_rise_point_finder.sv =====
// Self-checking testbench for ramp_rise_point_finder: drives sample captures on the
// input stream, predicts each capture's rise points and status, and checks the results.
// Depends on rrpf_pkg and the ramp_rise_point_finder RTL.
`timescale 1ns / 100ps

module tb_ramp_rise_point_finder;

    import rrpf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 250;
    localparam logic [APB_ADDR_W-1:0] UPPER_LIMIT_ADDR = APB_ADDR_W'(4 * REG_UPPER_LIMIT);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        int                  gap;
    } t_sample_item;

    // DUT ports, inputs at known values from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [11:0] sample, rest zero
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [11:0] point_a, [23:12] point_b, [35:24] spacing
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;         // [1:0] status
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Stimulus and expectation stores
    t_sample_item sample_queue[$];
    t_result      expected_verdicts[$];
    t_sample_item next_item;
    int           queued_count = 0;
    int           error_count  = 0;
    int           gap_count    = 0;
    int           results_seen = 0;
    int           stall_left   = 0;

    // Predictor copy of the threshold and of the capture search
    logic [SAMPLE_W-1:0] limit_copy = SAMPLE_W'(UPPER_LIMIT_RST);
    int                  cap_index  = 0;
    logic [SAMPLE_W-1:0] win_old    = '0;
    logic [SAMPLE_W-1:0] win_new    = '0;
    bit                  a_found    = 1'b0;
    int                  a_index    = 0;
    bit                  a_sat      = 1'b0;
    bit                  b_found    = 1'b0;
    int                  b_index    = 0;
    bit                  b_sat      = 1'b0;

    ramp_rise_point_finder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Record point B with its index and saturation flag
    task automatic mark_point_b(input int idx, input logic [SAMPLE_W-1:0] value);
        b_found = 1'b1;
        b_index = idx;
        b_sat   = (value >= SAT_LEVEL);
    endtask

    // Advance the rise search by one accepted sample; close the capture on last
    task automatic track_rise_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        t_result verdict;
        bit      had_a;
        if (cap_index < MAX_SAMPLES_DEF) begin
            had_a = a_found;
            if (had_a && !b_found && value > limit_copy)
                mark_point_b(cap_index, value);
            // glitch guard: A needs two non-decreasing samples after it
            if (!had_a && cap_index >= FIRST_CHECK_IDX && win_old > LOW_LIMIT_DEF &&
                win_old <= win_new && win_new <= value) begin
                a_found = 1'b1;
                a_index = cap_index - 2;
                a_sat   = (win_old >= SAT_LEVEL);
                if (win_new > limit_copy)
                    mark_point_b(cap_index - 1, win_new);
                else if (value > limit_copy)
                    mark_point_b(cap_index, value);
            end
            win_old   = win_new;
            win_new   = value;
            cap_index = cap_index + 1;
        end
        if (last) begin
            verdict = '0;
            if (!a_found || !b_found) begin
                verdict.status = ST_UNDERFLOW;
            end else if (b_index - a_index <= MIN_SPACING || a_sat || b_sat) begin
                verdict.status = ST_OVERFLOW;
            end else begin
                verdict.status  = ST_OK;
                verdict.point_a = POINT_W'(a_index);
                verdict.point_b = POINT_W'(b_index);
                verdict.spacing = POINT_W'(b_index - a_index);
            end
            expected_verdicts.push_back(verdict);
            cap_index = 0;
            win_old   = '0;
            win_new   = '0;
            a_found   = 1'b0;
            a_index   = 0;
            a_sat     = 1'b0;
            b_found   = 1'b0;
            b_index   = 0;
            b_sat     = 1'b0;
        end
    endtask

    // Sample driver: predict on each accepted transaction, then present the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                track_rise_sample(s_axis_tdata[SAMPLE_W-1:0], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (gap_count < sample_queue[0].gap) begin
                    gap_count = gap_count + 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_item = sample_queue.pop_front();
                    gap_count = 0;
                    s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, next_item.sample};
                    s_axis_tlast  <= next_item.last;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: check each transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result: status %0d, tdata %h", m_axis_tuser, m_axis_tdata);
                    error_count = error_count + 1;
                end else begin
                    t_result want;
                    want = expected_verdicts.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tdata[11:0] !== want.point_a) begin
                        $error("point_a: expected %0d, got %0d", want.point_a,
                               m_axis_tdata[11:0]);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tdata[23:12] !== want.point_b) begin
                        $error("point_b: expected %0d, got %0d", want.point_b,
                               m_axis_tdata[23:12]);
                        error_count = error_count + 1;
                    end
                    if (m_axis_tdata[35:24] !== want.spacing) begin
                        $error("spacing: expected %0d, got %0d", want.spacing,
                               m_axis_tdata[35:24]);
                        error_count = error_count + 1;
                    end
                end
                results_seen = results_seen + 1;
                // hold off long twice so the output slots fill and the input stalls
                if (results_seen == 20 || results_seen == 60)
                    stall_left = LONG_HOLD;
                else if ((results_seen / 16) % 3 == 2)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic push_sample(input int value, input bit last, input int gap);
        t_sample_item item;
        item.sample = SAMPLE_W'(value);
        item.last   = last;
        item.gap    = gap;
        sample_queue.push_back(item);
        queued_count = queued_count + 1;
    endtask

    // Queue a charging ramp: low lead-in, then a rise with random steps and rare glitches
    task automatic queue_ramp();
        bit calm;
        int lead_len;
        int rise_len;
        int step_max;
        int level;
        int value;
        calm     = ($urandom_range(0, 3) == 0);
        lead_len = $urandom_range(0, 6);
        rise_len = $urandom_range(3, 24);
        step_max = $urandom_range(20, 600);
        level    = $urandom_range(200, 900);
        for (int k = 0; k < lead_len; k++)
            push_sample($urandom_range(0, LOW_LIMIT_DEF), 1'b0, draw_gap(calm));
        for (int k = 0; k < rise_len; k++) begin
            value = level;
            if ($urandom_range(0, 9) == 0)
                value = $urandom_range(0, 4095);
            push_sample(value, k == rise_len - 1, draw_gap(calm));
            level = level + $urandom_range(0, step_max);
            if (level > 4095)
                level = 4095;
        end
    endtask

    // Queue random samples, biased above the low limit for short captures
    task automatic queue_noise(input int len, input int floor_value);
        bit calm;
        calm = ($urandom_range(0, 1) == 0);
        for (int k = 0; k < len; k++)
            push_sample($urandom_range(floor_value, 4095), k == len - 1, draw_gap(calm));
    endtask

    // Wait until all samples are taken and all results checked, then let the pipe settle
    task automatic wait_until_drained();
        while (sample_queue.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write upper_limit over APB, then read it back
    task automatic write_upper_limit(input logic [SAMPLE_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= UPPER_LIMIT_ADDR;
        pwdata  <= {{(APB_DATA_W - SAMPLE_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_copy = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[SAMPLE_W-1:0] !== value) begin
            $error("upper_limit: expected %0d, got %0d", value, prdata[SAMPLE_W-1:0]);
            error_count = error_count + 1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence: reset, directed captures, then random phases per threshold
    initial begin
        logic [SAMPLE_W-1:0] phase_limit;
        int                  pick;
        int                  phase_end;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single full-scale sample: too short to qualify A
        push_sample(4095, 1'b1, 0);
        // samples at the low limit never qualify A
        push_sample(0, 1'b0, 1);
        push_sample(0, 1'b0, 0);
        push_sample(LOW_LIMIT_DEF, 1'b0, 2);
        push_sample(LOW_LIMIT_DEF, 1'b0, 0);
        push_sample(LOW_LIMIT_DEF, 1'b0, 3);
        push_sample(3000, 1'b1, 0);
        // clean ramp, B found on the marked sample
        push_sample(0, 1'b0, 0);
        push_sample(0, 1'b0, 0);
        push_sample(500, 1'b0, 0);
        push_sample(600, 1'b0, 0);
        push_sample(700, 1'b0, 1);
        push_sample(3000, 1'b1, 0);
        // B two after A, checked as A qualifies
        push_sample(0, 1'b0, 0);
        push_sample(0, 1'b0, 0);
        push_sample(LOW_LIMIT_DEF + 1, 1'b0, 0);
        push_sample(LOW_LIMIT_DEF + 1, 1'b0, 0);
        push_sample(4095, 1'b1, 2);
        // saturated A with B right after it
        push_sample(0, 1'b0, 0);
        push_sample(0, 1'b0, 0);
        push_sample(SAT_LEVEL, 1'b0, 0);
        push_sample(4095, 1'b0, 0);
        push_sample(4095, 1'b0, 0);
        push_sample(4095, 1'b1, 0);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: phase_limit = '0;
                1: phase_limit = '1;
                3: phase_limit = SAMPLE_W'(UPPER_LIMIT_RST);
                default: phase_limit = SAMPLE_W'($urandom_range(LOW_LIMIT_DEF, 4000));
            endcase
            wait_until_drained();
            write_upper_limit(phase_limit);
            phase_end = queued_count + PHASE_ITEMS;
            while (queued_count < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    queue_noise($urandom_range(1, 4), LOW_LIMIT_DEF);
                else if (pick == 1)
                    queue_noise($urandom_range(1, 30), 0);
                else
                    queue_ramp();
            end
        end

        wait_until_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rrpf_pkg.sv
rtl/rrpf_search.sv
rtl/rrpf_out.sv
rtl/ramp_rise_point_finder.sv
rtl/rrpf_checker.sv
tb/tb_ramp_rise_point_finder.sv
